/* hdl/glw_pkg.sv */
// Shared types and constants for the grid line walker.
package glw_pkg;

  // Field widths
  localparam int COORD_W  = 5;
  localparam int DIM_W    = 6;
  localparam int DELTA_W  = 6;
  localparam int CROSS_W  = 8;
  // Error term: start value plus up to 62 scaled moves of at most 62 each
  localparam int ERR_W    = 13;
  localparam int CNT_W    = 6;

  // Walk limits
  localparam int RESULT_CAP = 63;
  localparam int ERR_SHIFT  = 1;  // error steps are scaled by two

  // Default grid limits
  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 32;
  localparam logic [DIM_W-1:0] GRID_RESET = 6'd32;

  // Register map: one 32-bit register every four bytes
  localparam int ADDR_W  = 3;
  localparam int REG_LSB = 2;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               last;
    logic               stop_reason;
  } out_word_t;

  // Grid bounds in use, already clipped to the build limits
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } bound_t;

  // Status from the step unit back to the sequencer
  typedef struct packed {
    logic signed [ERR_W-1:0] err_nxt;
    logic [COORD_W-1:0]      nxt_x;
    logic [COORD_W-1:0]      nxt_y;
    logic                    nxt_inside;
    logic                    cur_inside;
    logic                    at_target;
  } step_rsp_t;

endpackage

/* hdl/grid_line_walk.sv */
// Top level: sequencer around the shared step unit and config registers.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall  | in_data   (src and dst cell)
//  out     | output    | out_valid / out_stall| out_data  (cell, last, stop_reason)
//  cfg     | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// An item is taken in IDLE, its error term and source check are done in INIT, then
// one cell leaves per cycle through the step unit while out is not stalled, at most
// 63 cells. A source outside the grid goes from INIT back to IDLE and gives no words.
// Reset clears the sequencer, the output valid and sets both grid registers to 32.
// A stall on out holds the walk; in is stalled for the whole walk.
module grid_line_walk #(
  parameter int MAX_WIDTH  = glw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = glw_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  glw_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output glw_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glw_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import glw_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]              state_r, state_nxt;
  in_word_t                req_r, req_nxt;
  logic [COORD_W-1:0]      cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;
  bound_t                  bound;
  step_rsp_t               rsp;

  glw_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bound   (bound)
  );

  glw_step u_step (
    .init  (state_r == ST_INIT),
    .req   (req_r),
    .cur_x (cur_x_r),
    .cur_y (cur_y_r),
    .err   (err_r),
    .bound (bound),
    .rsp   (rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          cur_x_nxt = in_data.src_x;
          cur_y_nxt = in_data.src_y;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        // corner cross product seeds the error term
        err_nxt   = rsp.err_nxt;
        cnt_nxt   = '0;
        state_nxt = rsp.cur_inside ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.cell_x      = cur_x_r;
          out_word_nxt.cell_y      = cur_y_r;
          out_word_nxt.last        = 1'b0;
          out_word_nxt.stop_reason = 1'b0;
          if (rsp.at_target) begin
            out_word_nxt.last = 1'b1;
            state_nxt         = ST_IDLE;
          end else if (!rsp.nxt_inside) begin
            out_word_nxt.last        = 1'b1;
            out_word_nxt.stop_reason = 1'b1;
            state_nxt                = ST_IDLE;
          end else begin
            err_nxt   = rsp.err_nxt;
            cur_x_nxt = rsp.nxt_x;
            cur_y_nxt = rsp.nxt_y;
            cnt_nxt   = cnt_r + 1'b1;
            // word cap reached: end quietly
            if (cnt_r == CNT_W'(RESULT_CAP - 1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    err_r      <= err_nxt;
    out_word_r <= out_word_nxt;
  end

`ifndef ASSERT_OFF
  // accepted item goes to setup next
  a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_INIT))
    else $error("accepted item did not enter setup");

  // walk count stays below the word cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cnt_r < CNT_W'(RESULT_CAP)))
    else $error("walk count past cap");

  // a new word appears only out of the walk state
  a_emit_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && !(state_r == ST_WALK) |=> !out_valid_r)
    else $error("word emitted outside walk");

  // stop reason only on the final word
  a_reason_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.stop_reason) |-> out_word_r.last)
    else $error("stop reason without last");
`endif

endmodule

/* hdl/glw_cfg.sv */
// Configuration registers and clipped grid bounds for the line walker.
module glw_cfg #(
  parameter int MAX_WIDTH  = glw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = glw_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glw_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output glw_pkg::bound_t             bound
);
  import glw_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0] grid_width_r, grid_width_nxt;
  logic [DIM_W-1:0] grid_height_r, grid_height_nxt;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[REG_LSB];

  // Register write decode
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (wr_en) begin
      case (reg_sel)
        REG_GRID_WIDTH:  grid_width_nxt  = pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH:  prdata = 32'(grid_width_r);
      REG_GRID_HEIGHT: prdata = 32'(grid_height_r);
      default:         prdata = '0;
    endcase
  end

  // Bounds in use: smaller of register and build limit
  assign bound.width  = (grid_width_r  < MAX_W) ? grid_width_r  : MAX_W;
  assign bound.height = (grid_height_r < MAX_H) ? grid_height_r : MAX_H;

endmodule

/* hdl/glw_step.sv */
// Shared step unit: picks the move, updates the error term, checks bounds.
module glw_step (
  input  logic                         init,
  input  glw_pkg::in_word_t            req,
  input  logic [glw_pkg::COORD_W-1:0]  cur_x,
  input  logic [glw_pkg::COORD_W-1:0]  cur_y,
  input  logic signed [glw_pkg::ERR_W-1:0] err,
  input  glw_pkg::bound_t              bound,
  output glw_pkg::step_rsp_t           rsp
);
  import glw_pkg::*;

  localparam logic signed [1:0] P1 = 2'sb01;
  localparam logic signed [1:0] N1 = 2'sb11;
  localparam logic signed [1:0] Z0 = 2'sb00;

  logic signed [DELTA_W-1:0] dx, dy;
  logic                      dx_pos, dy_pos;
  logic signed [1:0]         kx, ky, ax, ay, bx, by, ux, uy;
  logic signed [CROSS_W-1:0] dx_ext, dy_ext, term_x, term_y, cr;
  logic signed [ERR_W-1:0]   cr_ext, base, addend;
  logic signed [COORD_W+1:0] nx, ny;

  // Deltas and quadrant
  assign dx = $signed({1'b0, req.dst_x}) - $signed({1'b0, req.src_x});
  assign dy = $signed({1'b0, req.dst_y}) - $signed({1'b0, req.src_y});
  assign dx_pos = !dx[DELTA_W-1] && (dx != '0);
  assign dy_pos = !dy[DELTA_W-1] && (dy != '0);

  // Corner, first and second step for each quadrant
  always_comb begin
    case ({dx_pos, dy_pos})
      2'b11: begin
        kx = P1; ky = P1; ax = P1; ay = Z0; bx = Z0; by = P1;
      end
      2'b10: begin
        kx = P1; ky = N1; ax = Z0; ay = N1; bx = P1; by = Z0;
      end
      2'b01: begin
        kx = N1; ky = P1; ax = Z0; ay = P1; bx = N1; by = Z0;
      end
      default: begin
        kx = N1; ky = N1; ax = N1; ay = Z0; bx = Z0; by = N1;
      end
    endcase
  end

  // Move choice: corner during setup, else by error sign (zero is diagonal)
  always_comb begin
    if (init) begin
      ux = kx; uy = ky;
    end else if (!err[ERR_W-1] && (err != '0)) begin
      ux = ax; uy = ay;
    end else if (err[ERR_W-1]) begin
      ux = bx; uy = by;
    end else begin
      ux = ax + bx; uy = ay + by;
    end
  end

  // Cross product of delta with unit move: dx*uy - dy*ux
  assign dx_ext = {{(CROSS_W-DELTA_W){dx[DELTA_W-1]}}, dx};
  assign dy_ext = {{(CROSS_W-DELTA_W){dy[DELTA_W-1]}}, dy};

  always_comb begin
    case (uy)
      P1:      term_y = dx_ext;
      N1:      term_y = -dx_ext;
      default: term_y = '0;
    endcase
    case (ux)
      P1:      term_x = dy_ext;
      N1:      term_x = -dy_ext;
      default: term_x = '0;
    endcase
  end

  assign cr     = term_y - term_x;
  assign cr_ext = {{(ERR_W-CROSS_W){cr[CROSS_W-1]}}, cr};

  // The one shared adder
  assign base        = init ? '0 : err;
  assign addend      = init ? cr_ext : (cr_ext <<< ERR_SHIFT);
  assign rsp.err_nxt = base + addend;

  // Next cell and bound checks
  assign nx = $signed({2'b00, cur_x}) + $signed({{COORD_W{ux[1]}}, ux});
  assign ny = $signed({2'b00, cur_y}) + $signed({{COORD_W{uy[1]}}, uy});

  assign rsp.nxt_x      = nx[COORD_W-1:0];
  assign rsp.nxt_y      = ny[COORD_W-1:0];
  assign rsp.nxt_inside = !nx[COORD_W+1] && (nx[COORD_W:0] < bound.width)
                       && !ny[COORD_W+1] && (ny[COORD_W:0] < bound.height);
  assign rsp.cur_inside = ({1'b0, cur_x} < bound.width)
                       && ({1'b0, cur_y} < bound.height);
  assign rsp.at_target  = (cur_x == req.dst_x) && (cur_y == req.dst_y);

endmodule

/* sim/glw_walk_checker.sv */
// Line walk checker: predicts the visited cells of each request and compares output words.
`timescale 1ns / 1ps

module glw_walk_checker
  import glw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fault_count,
  output int                cells_owed
);

  // Shadow copy of the grid registers
  logic [DIM_W-1:0] grid_w;
  logic [DIM_W-1:0] grid_h;

  // Cells still to come, oldest first
  out_word_t walk_cells[$];
  out_word_t want;

  // Cell test against the clipped grid bounds
  function automatic bit on_grid(int x, int y);
    int bw, bh;
    bw = (int'(grid_w) < MAX_WIDTH) ? int'(grid_w) : MAX_WIDTH;
    bh = (int'(grid_h) < MAX_HEIGHT) ? int'(grid_h) : MAX_HEIGHT;
    return (x >= 0) && (y >= 0) && (x < bw) && (y < bh);
  endfunction

  // Walk the line from source to target and queue every visited cell
  function automatic void trace_line(in_word_t req);
    int sx, sy, tx, ty, dx, dy;
    int kx, ky, ax, ay, bx, by, ux, uy;
    int cx, cy, err, n;
    out_word_t visit;
    sx = int'(req.src_x);
    sy = int'(req.src_y);
    tx = int'(req.dst_x);
    ty = int'(req.dst_y);
    dx = tx - sx;
    dy = ty - sy;
    // quadrant picks the corner and the ordered pair of unit steps
    if (dx > 0) begin
      if (dy > 0) begin
        kx = 1;  ky = 1;  ax = 1;  ay = 0;  bx = 0;  by = 1;
      end else begin
        kx = 1;  ky = -1; ax = 0;  ay = -1; bx = 1;  by = 0;
      end
    end else begin
      if (dy > 0) begin
        kx = -1; ky = 1;  ax = 0;  ay = 1;  bx = -1; by = 0;
      end else begin
        kx = -1; ky = -1; ax = -1; ay = 0;  bx = 0;  by = -1;
      end
    end
    err = dx * ky - dy * kx;
    cx  = sx;
    cy  = sy;
    if (!on_grid(cx, cy)) return;
    n = 0;
    while (n < RESULT_CAP) begin
      visit.cell_x      = cx[COORD_W-1:0];
      visit.cell_y      = cy[COORD_W-1:0];
      visit.last        = 1'b0;
      visit.stop_reason = 1'b0;
      n++;
      if (cx == tx && cy == ty) begin
        visit.last = 1'b1;
        walk_cells.push_back(visit);
        break;
      end
      // positive term: first step, negative: second, zero: diagonal
      if (err > 0) begin
        ux = ax;      uy = ay;
      end else if (err < 0) begin
        ux = bx;      uy = by;
      end else begin
        ux = ax + bx; uy = ay + by;
      end
      if (!on_grid(cx + ux, cy + uy)) begin
        visit.last        = 1'b1;
        visit.stop_reason = 1'b1;
        walk_cells.push_back(visit);
        break;
      end
      walk_cells.push_back(visit);
      err += (dx * uy - dy * ux) * (1 << ERR_SHIFT);
      cx += ux;
      cy += uy;
    end
  endfunction

  // Compare output words first, then predict new requests, then track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      grid_w = GRID_RESET;
      grid_h = GRID_RESET;
      walk_cells.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (walk_cells.size() == 0) begin
          $error("unexpected word: cell (%0d,%0d) last %0b stop_reason %0b",
                 out_data.cell_x, out_data.cell_y, out_data.last, out_data.stop_reason);
          fault_count++;
        end else begin
          want = walk_cells.pop_front();
          if (out_data.cell_x !== want.cell_x) begin
            $error("cell_x: expected %0d, got %0d", want.cell_x, out_data.cell_x);
            fault_count++;
          end
          if (out_data.cell_y !== want.cell_y) begin
            $error("cell_y: expected %0d, got %0d", want.cell_y, out_data.cell_y);
            fault_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            fault_count++;
          end
          if (out_data.stop_reason !== want.stop_reason) begin
            $error("stop_reason: expected %0b, got %0b", want.stop_reason,
                   out_data.stop_reason);
            fault_count++;
          end
        end
      end
      if (in_valid && !in_stall) trace_line(in_data);
      if (psel && penable && pwrite && pready) begin
        if (paddr[ADDR_W-1:REG_LSB] == REG_GRID_WIDTH) grid_w = pwdata[DIM_W-1:0];
        else if (paddr[ADDR_W-1:REG_LSB] == REG_GRID_HEIGHT) grid_h = pwdata[DIM_W-1:0];
      end
    end
    cells_owed = walk_cells.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top: drives line requests and register writes into the walker and reports.
`timescale 1ns / 1ps

module tb_top;
  import glw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 11;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int  fault_count;
  int  cells_owed;
  int  cycle_count = 0;
  bit  quiet       = 1'b0;
  bit  hold_req    = 1'b0;
  int  cur_w       = 32;
  int  cur_h       = 32;

  // Grid settings per random phase; a negative entry means pick one at random
  int  phase_w [NUM_PHASES] = '{32, 63, 20, 1, 32, -1, 32};
  int  phase_h [NUM_PHASES] = '{32, 63, 12, 32, 1, -1, 32};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  grid_line_walk u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  glw_walk_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fault_count (fault_count),
    .cells_owed  (cells_owed)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("grid_line_walk test failed");
      $finish;
    end
  end

  // Receiver: one long hold on request, short random stall bursts otherwise
  initial begin : rx_side
    int burst;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(1, 10);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(logic idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(idx) << REG_LSB;
    pwdata  = 32'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Set both grid registers; the walker should be idle, which the task itself does not wait for
  task automatic set_grid(int w, int h);
    apb_write(REG_GRID_WIDTH, DIM_W'(w));
    apb_write(REG_GRID_HEIGHT, DIM_W'(h));
    cur_w = w;
    cur_h = h;
  endtask

  // Offer one request word, maybe after a random gap, and wait until it is taken
  task automatic offer(in_word_t req);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every cell to arrive, then let a trailing no-result walk finish
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (cells_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random request: mostly sources on the grid, with straight, diagonal and short lines
  function automatic in_word_t rand_line(int gw, int gh);
    in_word_t req;
    int bw, bh, mode, sx, sy, tx, ty, d;
    bw = (gw < DEF_MAX_WIDTH) ? gw : DEF_MAX_WIDTH;
    bh = (gh < DEF_MAX_HEIGHT) ? gh : DEF_MAX_HEIGHT;
    sx = $urandom_range(0, 31);
    sy = $urandom_range(0, 31);
    tx = $urandom_range(0, 31);
    ty = $urandom_range(0, 31);
    mode = $urandom_range(0, 9);
    if (mode > 0 && bw > 0 && bh > 0) begin
      sx = $urandom_range(0, bw - 1);
      sy = $urandom_range(0, bh - 1);
    end
    d = $urandom_range(1, 31);
    case (mode)
      1: begin
        tx = sx;
        ty = sy;
      end
      2: tx = sx;
      3: ty = sy;
      4: begin
        tx = $urandom_range(0, 1) ? sx + d : sx - d;
        ty = $urandom_range(0, 1) ? sy + d : sy - d;
      end
      5: begin
        tx = sx + int'($urandom_range(0, 6)) - 3;
        ty = sy + int'($urandom_range(0, 6)) - 3;
      end
      default: ;
    endcase
    if (tx < 0 || tx > 31) tx = $urandom_range(0, 31);
    if (ty < 0 || ty > 31) ty = $urandom_range(0, 31);
    req.src_x = COORD_W'(sx);
    req.src_y = COORD_W'(sy);
    req.dst_x = COORD_W'(tx);
    req.dst_y = COORD_W'(ty);
    return req;
  endfunction

  initial begin : stimulus
    int w, h;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Full 32x32 grid from reset: corners, diagonals, axis lines, single cell
    offer({5'd0, 5'd0, 5'd31, 5'd31});
    offer({5'd31, 5'd31, 5'd0, 5'd0});
    offer({5'd0, 5'd31, 5'd31, 5'd0});
    offer({5'd31, 5'd0, 5'd0, 5'd31});
    offer({5'd5, 5'd5, 5'd5, 5'd5});
    offer({5'd0, 5'd0, 5'd31, 5'd0});
    offer({5'd0, 5'd0, 5'd0, 5'd31});
    offer({5'd31, 5'd31, 5'd31, 5'd0});
    offer({5'd31, 5'd31, 5'd0, 5'd31});
    offer({5'd3, 5'd7, 5'd20, 5'd12});
    offer({5'd20, 5'd12, 5'd3, 5'd7});
    offer({5'd0, 5'd0, 5'd31, 5'd30});
    offer({5'd31, 5'd0, 5'd0, 5'd1});
    offer({5'd10, 5'd2, 5'd1, 5'd29});
    drain;

    // Small grid: source off the grid, walks that leave the grid
    set_grid(20, 12);
    offer({5'd25, 5'd3, 5'd0, 5'd0});
    offer({5'd19, 5'd11, 5'd31, 5'd31});
    offer({5'd0, 5'd0, 5'd31, 5'd31});
    offer({5'd5, 5'd10, 5'd5, 5'd31});
    drain;

    // Zero width or height leaves no cell on the grid; 63 is clipped
    set_grid(0, 63);
    offer({5'd0, 5'd0, 5'd3, 5'd3});
    offer({5'd31, 5'd31, 5'd0, 5'd0});
    drain;
    set_grid(63, 0);
    offer({5'd0, 5'd0, 5'd0, 5'd0});
    offer({5'd2, 5'd31, 5'd9, 5'd1});
    drain;

    // Single cell grid
    set_grid(1, 1);
    offer({5'd0, 5'd0, 5'd0, 5'd0});
    offer({5'd0, 5'd0, 5'd5, 5'd5});
    drain;

    // Random phases; the first one starts under a long receiver hold
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = (phase_w[p] < 0) ? int'($urandom_range(1, 63)) : phase_w[p];
      h = (phase_h[p] < 0) ? int'($urandom_range(1, 63)) : phase_h[p];
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      set_grid(w, h);
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) offer(rand_line(cur_w, cur_h));
      drain;
    end

    repeat (10) @(negedge clk);
    if (fault_count == 0) begin
      $display("grid_line_walk test passed");
    end else begin
      $display("grid_line_walk test failed");
    end
    $finish;
  end

endmodule

/* grid_line_walk.f */
hdl/glw_pkg.sv
hdl/glw_cfg.sv
hdl/glw_step.sv
hdl/grid_line_walk.sv
sim/glw_walk_checker.sv
sim/tb_top.sv
